// ===== src/sdtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// Sizes, request and result codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    // queue sizing
    localparam int DEPTH       = 16;
    localparam int TICK_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int NRES_W = $clog2(MAX_RESULTS);

    // request and result field widths
    localparam int ID_W        = 4;
    localparam int REQ_W       = 2;
    localparam int KIND_W      = 3;
    localparam int FIELD_DL_W  = 32;
    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 8;

    // request types
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [ID_W-1:0]      id_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED   = 3'd0,
        KIND_REMOVED = 3'd1,
        KIND_EXPIRED = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_FULL    = 3'd4
    } kind_t;

    // source of the id in a result
    typedef enum logic [1:0] {
        IDSEL_REQ  = 2'd0,
        IDSEL_HEAD = 2'd1,
        IDSEL_ZERO = 2'd2
    } id_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_FIND   = 3'd1,
        ST_INSERT = 3'd2,
        ST_REPLY  = 3'd3,
        ST_TICK   = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    idx_clr;
        logic    idx_inc;
        logic    del_en;
        logic    del_head;
        logic    ins_en;
        logic    n_clr;
        logic    n_inc;
        logic    out_load;
        kind_t   out_kind;
        id_sel_t out_sel;
        logic    out_present;
        logic    out_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_end;
        logic id_match;
        logic dl_le;
        logic full;
        logic head_exp;
        logic next_exp;
        logic n_lim;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/sorted_deadline_timer_queue.sv =====
// Sequence: an add or move scans the queue for the id, then scans for the insert point, then
//   loads the result; a remove scans for the id, then loads the result; a tick pops one
//   expired head per result, one per cycle while the output register is free.
// Throughput: one request at a time; the one-entry-per-cycle scan of the queue sets the rate.
//   A result waiting in the output register does not block the next request from being taken.
// Reset: clears the queue count, the sequencer and the output valid; entry storage is not
//   cleared, since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: timer queue sorted by deadline
// Add, move, remove and expiry tick requests over a stream interface.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sdtq_pkg::TDATA_IN_W-1:0]   s_tdata,  // timer_id, deadline, now_ticks
    input  wire logic [sdtq_pkg::REQ_W-1:0]        s_tuser,  // req_type
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sdtq_pkg::TDATA_OUT_W-1:0]       m_tdata,  // result_id, was_present
    output logic [sdtq_pkg::KIND_W-1:0]            m_tuser,  // result_kind
    output logic                                   m_tlast   // last_result
);

    sdtq_pkg::cmd_t  cmd;
    sdtq_pkg::sts_t  sts;
    sdtq_pkg::id_t   in_id;
    sdtq_pkg::tick_t in_dl;
    sdtq_pkg::tick_t in_now;
    sdtq_pkg::kind_t out_kind;
    sdtq_pkg::id_t   out_id;
    logic            out_present;

    // request unpacking
    assign in_id  = s_tdata[sdtq_pkg::ID_W-1:0];
    assign in_dl  = sdtq_pkg::tick_t'(s_tdata[sdtq_pkg::ID_W +: sdtq_pkg::FIELD_DL_W]);
    assign in_now = sdtq_pkg::tick_t'(
        s_tdata[sdtq_pkg::ID_W + sdtq_pkg::FIELD_DL_W +: sdtq_pkg::FIELD_DL_W]);

    sdtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    sdtq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_id       (in_id),
        .in_dl       (in_dl),
        .in_now      (in_now),
        .m_tready    (m_tready),
        .sts         (sts),
        .m_valid     (m_tvalid),
        .out_kind    (out_kind),
        .out_id      (out_id),
        .out_present (out_present),
        .out_last    (m_tlast)
    );

    // result packing
    assign m_tuser = out_kind;
    assign m_tdata = {{(sdtq_pkg::TDATA_OUT_W - sdtq_pkg::ID_W - 1){1'b0}}, out_present, out_id};

    // never insert into a full queue
    a_ins_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_en |-> !sts.full)
        else $error("insert into full queue");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    // delete and insert never share a cycle
    a_del_ins_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.del_en && cmd.ins_en))
        else $error("delete and insert together");

    // an expired pop always carries the head entry with a valid queue
    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.del_en && cmd.del_head) |-> (sts.head_exp && cmd.out_load))
        else $error("head pop without expiry");

endmodule
`default_nettype wire

// ===== src/sdtq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_dp: queue storage and result register
// Sorted entry array with masked shift for delete and insert, a scan index
// with one read port, request capture and the output register.
// ----------------------------------------------------------------------------
module sdtq_dp (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sdtq_pkg::cmd_t   cmd,
    input  wire sdtq_pkg::id_t    in_id,
    input  wire sdtq_pkg::tick_t  in_dl,
    input  wire sdtq_pkg::tick_t  in_now,
    input  wire logic             m_tready,
    output sdtq_pkg::sts_t        sts,
    output logic                  m_valid,
    output sdtq_pkg::kind_t       out_kind,
    output sdtq_pkg::id_t         out_id,
    output logic                  out_present,
    output logic                  out_last
);

    // entry storage, only entries below the count are meaningful
    sdtq_pkg::id_t   ids_reg [sdtq_pkg::DEPTH];
    sdtq_pkg::tick_t dls_reg [sdtq_pkg::DEPTH];

    // neighbor taps for shifting
    sdtq_pkg::id_t   up_id [sdtq_pkg::DEPTH];
    sdtq_pkg::tick_t up_dl [sdtq_pkg::DEPTH];
    sdtq_pkg::id_t   dn_id [sdtq_pkg::DEPTH];
    sdtq_pkg::tick_t dn_dl [sdtq_pkg::DEPTH];

    logic [sdtq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [sdtq_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [sdtq_pkg::NRES_W-1:0] n_reg, n_next;
    logic [sdtq_pkg::CNT_W-1:0]  pos;
    logic [sdtq_pkg::IDX_W-1:0]  rd_idx;

    sdtq_pkg::id_t   req_id_reg;
    sdtq_pkg::tick_t req_dl_reg;
    sdtq_pkg::tick_t req_now_reg;

    logic            m_valid_reg;
    sdtq_pkg::kind_t out_kind_reg;
    sdtq_pkg::id_t   out_id_reg;
    logic            out_present_reg;
    logic            out_last_reg;
    sdtq_pkg::id_t   sel_id;

    for (genvar g = 0; g < sdtq_pkg::DEPTH; g++) begin : g_tap
        if (g < sdtq_pkg::DEPTH - 1) begin : g_up
            assign up_id[g] = ids_reg[g+1];
            assign up_dl[g] = dls_reg[g+1];
        end else begin : g_up_end
            assign up_id[g] = ids_reg[g];
            assign up_dl[g] = dls_reg[g];
        end
        if (g > 0) begin : g_dn
            assign dn_id[g] = ids_reg[g-1];
            assign dn_dl[g] = dls_reg[g-1];
        end else begin : g_dn_end
            assign dn_id[g] = ids_reg[g];
            assign dn_dl[g] = dls_reg[g];
        end
    end

    assign pos    = cmd.del_head ? '0 : idx_reg;
    assign rd_idx = idx_reg[sdtq_pkg::IDX_W-1:0];

    // per-entry delete or insert, each entry looks only at its neighbors and the request
    always_ff @(posedge aclk) begin
        for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
            if (cmd.del_en && (sdtq_pkg::CNT_W'(i) >= pos)) begin
                ids_reg[i] <= up_id[i];
                dls_reg[i] <= up_dl[i];
            end else if (cmd.ins_en && (sdtq_pkg::CNT_W'(i) == pos)) begin
                ids_reg[i] <= req_id_reg;
                dls_reg[i] <= req_dl_reg;
            end else if (cmd.ins_en && (sdtq_pkg::CNT_W'(i) > pos)) begin
                ids_reg[i] <= dn_id[i];
                dls_reg[i] <= dn_dl[i];
            end
        end
    end

    // counters
    always_comb begin
        count_next = count_reg;
        if (cmd.del_en) begin
            count_next = count_reg - sdtq_pkg::CNT_W'(1);
        end else if (cmd.ins_en) begin
            count_next = count_reg + sdtq_pkg::CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + sdtq_pkg::CNT_W'(1);
        end
        n_next = n_reg;
        if (cmd.n_clr) begin
            n_next = '0;
        end else if (cmd.n_inc) begin
            n_next = n_reg + sdtq_pkg::NRES_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_id_reg  <= in_id;
            req_dl_reg  <= in_dl;
            req_now_reg <= in_now;
        end
    end

    // result id source
    always_comb begin
        unique case (cmd.out_sel)
            sdtq_pkg::IDSEL_REQ:  sel_id = req_id_reg;
            sdtq_pkg::IDSEL_HEAD: sel_id = ids_reg[0];
            default:              sel_id = '0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind_reg    <= cmd.out_kind;
            out_id_reg      <= sel_id;
            out_present_reg <= cmd.out_present;
            out_last_reg    <= cmd.out_last;
        end
    end

    // status to controller
    always_comb begin
        sts.idx_end  = (idx_reg == count_reg);
        sts.id_match = (ids_reg[rd_idx] == req_id_reg);
        sts.dl_le    = (dls_reg[rd_idx] <= req_dl_reg);
        sts.full     = (count_reg == sdtq_pkg::CNT_W'(sdtq_pkg::DEPTH));
        sts.head_exp = (count_reg != '0) && (dls_reg[0] < req_now_reg);
        sts.next_exp = (count_reg > sdtq_pkg::CNT_W'(1)) && (dls_reg[1] < req_now_reg);
        sts.n_lim    = (n_reg == sdtq_pkg::NRES_W'(sdtq_pkg::MAX_RESULTS - 1));
        sts.out_free = !m_valid_reg || m_tready;
    end

    assign m_valid     = m_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_id      = out_id_reg;
    assign out_present = out_present_reg;
    assign out_last    = out_last_reg;

endmodule
`default_nettype wire

// ===== src/sdtq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_ctrl: request sequencer
// Walks the queue one entry per cycle to find an id or an insert point, and
// pops expired head entries one per result.
// ----------------------------------------------------------------------------
module sdtq_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic [sdtq_pkg::REQ_W-1:0]  req_type,
    input  wire sdtq_pkg::sts_t              sts,
    output logic                             s_tready,
    output sdtq_pkg::cmd_t                   cmd
);

    sdtq_pkg::state_t state_reg, state_next;
    sdtq_pkg::kind_t  kind_reg, kind_next;
    logic             present_reg, present_next;
    logic             is_add_reg, is_add_next;
    logic             tick_last;

    // state and reply registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdtq_pkg::ST_IDLE;
            kind_reg    <= sdtq_pkg::KIND_ADDED;
            present_reg <= 1'b0;
            is_add_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            present_reg <= present_next;
            is_add_reg  <= is_add_next;
        end
    end

    // last expired result when the next head will not expire or the cap is hit
    assign tick_last = !(sts.next_exp && !sts.n_lim);

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        present_next = present_reg;
        is_add_next  = is_add_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.out_kind = sdtq_pkg::KIND_ADDED;
        cmd.out_sel  = sdtq_pkg::IDSEL_REQ;
        unique case (state_reg)
            sdtq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    cmd.n_clr    = 1'b1;
                    is_add_next  = (req_type == sdtq_pkg::REQ_ADD);
                    if (req_type == sdtq_pkg::REQ_ADD || req_type == sdtq_pkg::REQ_REMOVE) begin
                        state_next = sdtq_pkg::ST_FIND;
                    end else if (req_type == sdtq_pkg::REQ_TICK) begin
                        state_next = sdtq_pkg::ST_TICK;
                    end
                end
            end
            sdtq_pkg::ST_FIND: begin
                if (sts.idx_end) begin
                    if (!is_add_reg) begin
                        kind_next    = sdtq_pkg::KIND_REMOVED;
                        present_next = 1'b0;
                        state_next   = sdtq_pkg::ST_REPLY;
                    end else if (sts.full) begin
                        kind_next    = sdtq_pkg::KIND_FULL;
                        present_next = 1'b0;
                        state_next   = sdtq_pkg::ST_REPLY;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = sdtq_pkg::ST_INSERT;
                    end
                end else if (sts.id_match) begin
                    // unlink the old entry, a move then reinserts it
                    cmd.del_en  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (is_add_reg) begin
                        state_next = sdtq_pkg::ST_INSERT;
                    end else begin
                        kind_next    = sdtq_pkg::KIND_REMOVED;
                        present_next = 1'b1;
                        state_next   = sdtq_pkg::ST_REPLY;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            sdtq_pkg::ST_INSERT: begin
                // insert behind every entry with a deadline not above the new one
                if (sts.idx_end || !sts.dl_le) begin
                    cmd.ins_en   = 1'b1;
                    kind_next    = sdtq_pkg::KIND_ADDED;
                    present_next = 1'b0;
                    state_next   = sdtq_pkg::ST_REPLY;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            sdtq_pkg::ST_REPLY: begin
                if (sts.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = kind_reg;
                    cmd.out_sel     = sdtq_pkg::IDSEL_REQ;
                    cmd.out_present = present_reg;
                    cmd.out_last    = 1'b1;
                    state_next      = sdtq_pkg::ST_IDLE;
                end
            end
            sdtq_pkg::ST_TICK: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.head_exp) begin
                        cmd.out_kind = sdtq_pkg::KIND_EXPIRED;
                        cmd.out_sel  = sdtq_pkg::IDSEL_HEAD;
                        cmd.out_last = tick_last;
                        cmd.del_en   = 1'b1;
                        cmd.del_head = 1'b1;
                        cmd.n_inc    = 1'b1;
                        if (tick_last) begin
                            state_next = sdtq_pkg::ST_IDLE;
                        end
                    end else begin
                        cmd.out_kind = sdtq_pkg::KIND_NONE;
                        cmd.out_sel  = sdtq_pkg::IDSEL_ZERO;
                        cmd.out_last = 1'b1;
                        state_next   = sdtq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sim/sdtq_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_queue_checker: result checker for the sorted deadline timer queue
// Watches both stream channels and keeps its own sorted copy of the timer
// queue. Each accepted request is applied to that copy, and the results it
// should cause are queued in order. Each accepted result is compared field by
// field with the oldest one waiting. The failure count and the number of
// results still due are handed to the test top.
// ----------------------------------------------------------------------------
module sdtq_queue_checker
    import sdtq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // timer_id, deadline, now_ticks
    input  wire logic [REQ_W-1:0]       s_tuser,   // req_type
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [TDATA_OUT_W-1:0] m_tdata,   // result_id, was_present
    input  wire logic [KIND_W-1:0]      m_tuser,   // result_kind
    input  wire logic                   m_tlast,   // last_result
    output int                          failures,
    output int                          results_due,
    output int                          results_checked
);

    typedef struct packed {
        kind_t kind;
        id_t   id;
        logic  present;
        logic  is_last;
    } timer_result_t;

    // shadow copy of the queue, head at slot 0
    id_t   shadow_ids [DEPTH];
    tick_t shadow_dls [DEPTH];
    int    shadow_count;

    timer_result_t due_results[$];
    int            err_count;
    int            seen_count;

    // slot that holds a timer id, or -1 when it is not queued
    function automatic int find_timer(id_t id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_ids[i] == id)
                return i;
        return -1;
    endfunction

    // close the gap left by a slot
    function automatic void unlink_timer(int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_ids[i] = shadow_ids[i + 1];
            shadow_dls[i] = shadow_dls[i + 1];
        end
        shadow_count--;
    endfunction

    // insert behind every entry whose deadline is not above the new one
    function automatic void insert_timer(id_t id, tick_t dl);
        int pos;
        pos = 0;
        while (pos < shadow_count && shadow_dls[pos] <= dl)
            pos++;
        for (int i = shadow_count; i > pos; i--) begin
            shadow_ids[i] = shadow_ids[i - 1];
            shadow_dls[i] = shadow_dls[i - 1];
        end
        shadow_ids[pos] = id;
        shadow_dls[pos] = dl;
        shadow_count++;
    endfunction

    function automatic void push_result(kind_t kind, id_t id, logic present, logic is_last);
        timer_result_t r;
        r.kind    = kind;
        r.id      = id;
        r.present = present;
        r.is_last = is_last;
        due_results.push_back(r);
    endfunction

    // apply one request to the shadow queue and queue the results it causes
    function automatic void apply_timer_request(logic [REQ_W-1:0] req, id_t id, tick_t dl,
                                                tick_t now);
        int slot;
        int popped;
        case (req)
            REQ_ADD: begin
                slot = find_timer(id);
                if (slot >= 0) begin
                    unlink_timer(slot);
                    insert_timer(id, dl);
                    push_result(KIND_ADDED, id, 1'b0, 1'b1);
                end else if (shadow_count >= DEPTH) begin
                    push_result(KIND_FULL, id, 1'b0, 1'b1);
                end else begin
                    insert_timer(id, dl);
                    push_result(KIND_ADDED, id, 1'b0, 1'b1);
                end
            end
            REQ_REMOVE: begin
                slot = find_timer(id);
                if (slot >= 0)
                    unlink_timer(slot);
                push_result(KIND_REMOVED, id, slot >= 0, 1'b1);
            end
            REQ_TICK: begin
                popped = 0;
                while (popped < MAX_RESULTS && shadow_count > 0 && shadow_dls[0] < now) begin
                    push_result(KIND_EXPIRED, shadow_ids[0], 1'b0, 1'b0);
                    unlink_timer(0);
                    popped++;
                end
                if (popped == 0)
                    push_result(KIND_NONE, '0, 1'b0, 1'b1);
                else
                    due_results[due_results.size() - 1].is_last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // compare results, then take new requests, at each clock edge
    always @(posedge aclk) begin : watch
        timer_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen_count++;
                if (due_results.size() == 0) begin
                    err_count++;
                    $error("unexpected result: kind %0d id %0d", m_tuser, m_tdata[ID_W-1:0]);
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        err_count++;
                        $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
                    end
                    if (m_tdata[ID_W-1:0] !== want.id) begin
                        err_count++;
                        $error("result_id: expected %0d, got %0d", want.id,
                               m_tdata[ID_W-1:0]);
                    end
                    if (m_tdata[ID_W] !== want.present) begin
                        err_count++;
                        $error("was_present: expected %0d, got %0d", want.present,
                               m_tdata[ID_W]);
                    end
                    if (m_tlast !== want.is_last) begin
                        err_count++;
                        $error("last_result: expected %0d, got %0d", want.is_last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_timer_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: TICK_BITS],
                                    s_tdata[ID_W + TICK_BITS +: TICK_BITS]);
        end
        failures        <= err_count;
        results_due     <= due_results.size();
        results_checked <= seen_count;
    end

endmodule

// ===== sim/sorted_deadline_timer_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_test: top of the timer queue test
// Drives directed and random add, move, remove and tick requests in bursts,
// stalls the result side on its own pattern, and gives the verdict from the
// failure count of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_test;
    import sdtq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PAD_W        = TDATA_IN_W - ID_W - 2 * TICK_BITS;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    int failures;
    int results_due;
    int results_checked;

    int    cycle_count = 0;
    int    ready_run   = 0;
    int    burst_left  = 0;
    int    gap;
    int    n_add, n_remove, n_tick, n_ignored;
    int    pick;
    tick_t sim_now;
    tick_t last_dl;
    tick_t dl;
    tick_t now;

    always #6 aclk = ~aclk;

    sorted_deadline_timer_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sdtq_queue_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .failures        (failures),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout with %0d results still due", results_due);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: alternating ready and stall runs, now and then a long ready stretch
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            m_tready <= !m_tready;
            if (m_tready)
                ready_run = $urandom_range(1, 6);
            else if ($urandom_range(0, 5) == 0)
                ready_run = $urandom_range(40, 80);
            else
                ready_run = $urandom_range(1, 15);
        end else begin
            ready_run--;
        end
    end

    // send one request, opening a new burst after a random gap when one runs out
    task automatic issue_request(input logic [REQ_W-1:0] req, input id_t id,
                                 input tick_t req_dl, input tick_t req_now);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{PAD_W{1'b0}}, req_now, req_dl, id};
        do @(posedge aclk); while (!s_tready);
        case (req)
            REQ_ADD:    n_add++;
            REQ_REMOVE: n_remove++;
            REQ_TICK:   n_tick++;
            default:    n_ignored++;
        endcase
    endtask

    initial begin
        n_add     = 0;
        n_remove  = 0;
        n_tick    = 0;
        n_ignored = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, ties, moves, unused request type
        issue_request(REQ_TICK, 4'd0, '0, '0);
        issue_request(REQ_REMOVE, 4'd3, '0, '1);
        issue_request(REQ_ADD, 4'd15, '1, '0);
        issue_request(REQ_ADD, 4'd0, '0, '1);
        issue_request(REQ_ADD, 4'd5, 32'd100, '0);
        issue_request(REQ_ADD, 4'd6, 32'd100, '0);
        issue_request(REQ_ADD, 4'd5, 32'd100, '0);
        issue_request(REQ_REMOVE, 4'd6, '1, '0);
        issue_request(REQ_UNUSED, 4'd9, '1, '1);
        issue_request(REQ_TICK, 4'd15, '1, '0);
        issue_request(REQ_TICK, 4'd0, '0, 32'd101);
        issue_request(REQ_TICK, 4'd0, '0, '1);

        // fill to the full depth with tied deadlines, move on a full queue, drain it all
        for (int i = 0; i < DEPTH - 1; i++)
            issue_request(REQ_ADD, id_t'(i), 32'h8000_0000 + (i % 3) * 5, '0);
        issue_request(REQ_ADD, 4'd15, '0, '0);
        issue_request(REQ_TICK, 4'd0, '0, '1);

        // random traffic around a slowly advancing tick count
        sim_now = $urandom;
        last_dl = sim_now;
        while (n_add + n_remove + n_tick < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    dl = sim_now + $urandom_range(0, 300);
                else if (pick < 75)
                    dl = last_dl;
                else if (pick < 85)
                    dl = $urandom;
                else if (pick < 95)
                    dl = $urandom_range(0, 1) ? '1 : '0;
                else
                    dl = sim_now - $urandom_range(1, 50);
                last_dl = dl;
                issue_request(REQ_ADD, id_t'($urandom_range(0, 15)), dl, $urandom);
            end else if (pick < 65) begin
                issue_request(REQ_REMOVE, id_t'($urandom_range(0, 15)), $urandom, $urandom);
            end else if (pick < 96) begin
                sim_now += $urandom_range(0, 80);
                pick = $urandom_range(0, 99);
                if (pick < 87)
                    now = sim_now;
                else if (pick < 92)
                    now = $urandom;
                else if (pick < 97)
                    now = '1;
                else
                    now = '0;
                issue_request(REQ_TICK, id_t'($urandom_range(0, 15)), $urandom, now);
            end else begin
                issue_request(REQ_UNUSED, id_t'($urandom_range(0, 15)), $urandom, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for a stray late result
        do @(posedge aclk); while (results_due != 0);
        repeat (2 * DEPTH + 8) @(posedge aclk);

        $display("Sent %0d adds, %0d removes, %0d ticks and %0d unused-type requests;",
                 n_add, n_remove, n_tick, n_ignored);
        $display("compared %0d results, including full-queue moves and maximal expiry bursts.",
                 results_checked);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
